// ===== hdl/rrts_pkg.sv =====
// ----------------------------------------------------------------------------
// rrts_pkg
// Shared types, constants and helpers of the round-robin task scheduler.
// ----------------------------------------------------------------------------
package rrts_pkg;

  // ring sizing
  localparam int unsigned MaxTasks = 16;
  localparam int unsigned IdxW     = $clog2(MaxTasks);
  localparam int unsigned CntW     = $clog2(MaxTasks + 1);
  localparam int unsigned NumRings = 3;
  localparam int unsigned RamDepth = NumRings << IdxW;
  localparam int unsigned RamAw    = IdxW + 2;

  // field widths
  localparam int unsigned TaskW    = 4;
  localparam int unsigned OpW      = 3;
  localparam int unsigned BufCntW  = 8;
  localparam int unsigned StatusW  = 3;
  localparam int unsigned InDataW  = 24;
  localparam int unsigned OutDataW = 16;

  // configuration port
  localparam int unsigned CfgAw     = 3;
  localparam int unsigned CfgDw     = 32;
  localparam int unsigned LimitW    = 8;
  localparam logic [LimitW-1:0] LimitReset = 8'd64;

  typedef enum logic [OpW-1:0] {
    OP_ADMIT  = 3'd0,
    OP_START  = 3'd1,
    OP_TICK   = 3'd2,
    OP_RWAIT  = 3'd3,
    OP_WWAIT  = 3'd4,
    OP_RWAKE  = 3'd5,
    OP_WWAKE  = 3'd6
  } op_e;

  typedef enum logic [1:0] {
    RING_READY = 2'd0,
    RING_RWAIT = 2'd1,
    RING_WWAIT = 2'd2
  } ring_e;

  typedef enum logic [StatusW-1:0] {
    ST_OK     = 3'd0,
    ST_EMPTY  = 3'd1,
    ST_FULL   = 3'd2,
    ST_NOCUR  = 3'd3,
    ST_UNMET  = 3'd4
  } status_e;

  // what one request will do to the rings and the current task
  typedef struct packed {
    status_e          status;
    logic             pop_en;
    ring_e            pop_ring;
    logic             push_en;
    ring_e            push_ring;
    logic [TaskW-1:0] push_task;
    logic             sw_fix;   // switch reported unconditionally
    logic             sw_cmp;   // switch only if the popped id differs
    logic             go_idle;  // nothing runs afterwards
  } plan_t;

  // result layout, lowest field in the lowest bits
  typedef struct packed {
    status_e          status;
    logic             running_valid;
    logic [TaskW-1:0] new_task;
    logic [TaskW-1:0] old_task;
    logic             switched;
  } result_t;

  typedef logic [NumRings-1:0][IdxW-1:0] heads_t;
  typedef logic [NumRings-1:0][CntW-1:0] counts_t;

  function automatic logic [IdxW-1:0] head_sel(heads_t heads, ring_e ring);
    logic [IdxW-1:0] h;
    unique case (ring)
      RING_READY: h = heads[0];
      RING_RWAIT: h = heads[1];
      RING_WWAIT: h = heads[2];
      default:    h = heads[0];
    endcase
    return h;
  endfunction

  function automatic logic [CntW-1:0] count_sel(counts_t counts, ring_e ring);
    logic [CntW-1:0] c;
    unique case (ring)
      RING_READY: c = counts[0];
      RING_RWAIT: c = counts[1];
      RING_WWAIT: c = counts[2];
      default:    c = counts[0];
    endcase
    return c;
  endfunction

  function automatic logic [IdxW-1:0] idx_inc(logic [IdxW-1:0] idx);
    logic [IdxW-1:0] r;
    if (idx == IdxW'(MaxTasks - 1)) begin
      r = '0;
    end else begin
      r = idx + IdxW'(1);
    end
    return r;
  endfunction

  // tail slot: head + count, wrapped once (sum stays below twice the depth)
  function automatic logic [IdxW-1:0] tail_pos(logic [IdxW-1:0] head,
                                               logic [CntW-1:0] count);
    logic [CntW:0] sum;
    sum = (CntW+1)'(head) + (CntW+1)'(count);
    if (sum >= (CntW+1)'(MaxTasks)) begin
      sum = sum - (CntW+1)'(MaxTasks);
    end
    return sum[IdxW-1:0];
  endfunction

endpackage

// ===== hdl/rrts_ram.sv =====
// ----------------------------------------------------------------------------
// rrts_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module rrts_ram #(
  parameter int unsigned Width = 4,
  parameter int unsigned Depth = 48
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== hdl/rrts_apb_regs.sv =====
// ----------------------------------------------------------------------------
// rrts_apb_regs
// APB register file holding the write buffer limit.
// ----------------------------------------------------------------------------
module rrts_apb_regs (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [rrts_pkg::CfgAw-1:0]        paddr,
  input  logic [rrts_pkg::CfgDw-1:0]        pwdata,
  output logic [rrts_pkg::CfgDw-1:0]        prdata,
  output logic                              pready,
  output logic [rrts_pkg::LimitW-1:0]       limit_o
);

  logic [rrts_pkg::LimitW-1:0] limit_q, limit_d;
  logic                        hit_limit;

  // register 0 lives at byte address 0
  assign hit_limit = (paddr[rrts_pkg::CfgAw-1] == 1'b0);
  assign pready    = 1'b1;

  always_comb begin
    limit_d = limit_q;
    if (psel && penable && pwrite && hit_limit) begin
      limit_d = pwdata[rrts_pkg::LimitW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      limit_q <= rrts_pkg::LimitReset;
    end else begin
      limit_q <= limit_d;
    end
  end

  assign prdata  = hit_limit ? rrts_pkg::CfgDw'(limit_q) : '0;
  assign limit_o = limit_q;

endmodule

// ===== hdl/rrts_plan.sv =====
// ----------------------------------------------------------------------------
// rrts_plan
// Decode one request against ring fill and current task into a plan.
// ----------------------------------------------------------------------------
module rrts_plan (
  input  rrts_pkg::op_e                    opcode_i,
  input  logic [rrts_pkg::TaskW-1:0]       task_id_i,
  input  logic [rrts_pkg::BufCntW-1:0]     rd_count_i,
  input  logic [rrts_pkg::BufCntW-1:0]     wr_count_i,
  input  logic [rrts_pkg::LimitW-1:0]      limit_i,
  input  logic [rrts_pkg::TaskW-1:0]       cur_task_i,
  input  logic                             cur_valid_i,
  input  rrts_pkg::counts_t                counts_i,
  output rrts_pkg::plan_t                  plan_o
);

  logic [rrts_pkg::NumRings-1:0] full_v;
  logic [rrts_pkg::NumRings-1:0] empty_v;
  rrts_pkg::ring_e               wait_ring;
  logic                          wake_ok;

  always_comb begin
    for (int r = 0; r < rrts_pkg::NumRings; r++) begin
      full_v[r]  = (counts_i[r] == rrts_pkg::CntW'(rrts_pkg::MaxTasks));
      empty_v[r] = (counts_i[r] == '0);
    end
  end

  always_comb begin
    wait_ring = ((opcode_i == rrts_pkg::OP_RWAIT) || (opcode_i == rrts_pkg::OP_RWAKE))
              ? rrts_pkg::RING_RWAIT : rrts_pkg::RING_WWAIT;
    wake_ok   = (opcode_i == rrts_pkg::OP_RWAKE) ? (rd_count_i != '0)
                                                 : (wr_count_i < limit_i);

    plan_o           = '0;
    plan_o.status    = rrts_pkg::ST_OK;
    plan_o.pop_ring  = rrts_pkg::RING_READY;
    plan_o.push_ring = rrts_pkg::RING_READY;
    plan_o.push_task = cur_task_i;

    unique case (opcode_i)
      rrts_pkg::OP_ADMIT: begin
        if (full_v[rrts_pkg::RING_READY]) begin
          plan_o.status = rrts_pkg::ST_FULL;
        end else begin
          plan_o.push_en   = 1'b1;
          plan_o.push_task = task_id_i;
        end
      end
      rrts_pkg::OP_START: begin
        if (empty_v[rrts_pkg::RING_READY]) begin
          plan_o.status = rrts_pkg::ST_EMPTY;
        end else begin
          plan_o.pop_en = 1'b1;
          plan_o.sw_fix = 1'b1;
        end
      end
      rrts_pkg::OP_TICK: begin
        if (!cur_valid_i) begin
          plan_o.status = rrts_pkg::ST_NOCUR;
        end else if (!empty_v[rrts_pkg::RING_READY]) begin
          // head is read before the tail write, so a full ring still rotates
          plan_o.pop_en  = 1'b1;
          plan_o.push_en = 1'b1;
          plan_o.sw_cmp  = 1'b1;
        end
      end
      rrts_pkg::OP_RWAIT, rrts_pkg::OP_WWAIT: begin
        if (!cur_valid_i) begin
          plan_o.status = rrts_pkg::ST_NOCUR;
        end else if (full_v[wait_ring]) begin
          plan_o.status = rrts_pkg::ST_FULL;
        end else begin
          plan_o.push_en   = 1'b1;
          plan_o.push_ring = wait_ring;
          plan_o.sw_fix    = 1'b1;
          if (!empty_v[rrts_pkg::RING_READY]) begin
            plan_o.pop_en = 1'b1;
          end else begin
            plan_o.go_idle = 1'b1;
            plan_o.status  = rrts_pkg::ST_EMPTY;
          end
        end
      end
      rrts_pkg::OP_RWAKE, rrts_pkg::OP_WWAKE: begin
        if (empty_v[wait_ring] || !wake_ok) begin
          plan_o.status = rrts_pkg::ST_UNMET;
        end else if (cur_valid_i && full_v[rrts_pkg::RING_READY]) begin
          plan_o.status = rrts_pkg::ST_FULL;
        end else begin
          plan_o.push_en  = cur_valid_i;
          plan_o.pop_en   = 1'b1;
          plan_o.pop_ring = wait_ring;
          plan_o.sw_fix   = 1'b1;
        end
      end
      default: begin
        // unused opcode: no effect
      end
    endcase
  end

endmodule

// ===== hdl/round_robin_task_scheduler.sv =====
// ----------------------------------------------------------------------------
// round_robin_task_scheduler
// Round-robin scheduler over a ready ring and two wait rings of task ids.
// ----------------------------------------------------------------------------
// At acceptance the request is decoded and the head of the ring to be
// dequeued is read from the ring RAM; in the commit state that follows,
// the read data has returned, the tail write happens and the result is
// loaded into the output register. A result waiting in the output register
// does not block the next request from being accepted; the commit cycle
// holds only if the previous result has still not been taken. The three
// rings share one RAM (one row block per ring); heads, fill counts and the
// current task are kept in flip-flops and cleared by reset, so no clearing
// pass is needed. The write buffer limit sits at APB byte address 0 and
// resets to 64.
// ----------------------------------------------------------------------------
module round_robin_task_scheduler (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  // request stream
  input  logic                           s_axis_tvalid,
  output logic                           s_axis_tready,
  // [3:0] task_id, [11:4] read_buffer_count, [19:12] write_buffer_count
  input  logic [rrts_pkg::InDataW-1:0]   s_axis_tdata,
  // [2:0] opcode
  input  logic [rrts_pkg::OpW-1:0]       s_axis_tuser,
  // result stream
  output logic                           m_axis_tvalid,
  input  logic                           m_axis_tready,
  // [0] switched, [4:1] old_task, [8:5] new_task, [9] running_valid,
  // [12:10] status
  output logic [rrts_pkg::OutDataW-1:0]  m_axis_tdata,
  // configuration
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [rrts_pkg::CfgAw-1:0]     paddr,
  input  logic [rrts_pkg::CfgDw-1:0]     pwdata,
  output logic [rrts_pkg::CfgDw-1:0]     prdata,
  output logic                           pready
);

  typedef enum logic [1:0] {
    S_IDLE   = 2'b01,
    S_COMMIT = 2'b10
  } state_e;

  state_e                          state_q, state_d;
  rrts_pkg::plan_t                 plan_now, plan_q;
  rrts_pkg::heads_t                heads_q, heads_d;
  rrts_pkg::counts_t               counts_q, counts_d;
  logic [rrts_pkg::TaskW-1:0]      cur_task_q, cur_task_d;
  logic                            cur_valid_q, cur_valid_d;
  logic                            out_valid_q, out_valid_d;
  rrts_pkg::result_t               out_res_q, res_d;
  logic [rrts_pkg::LimitW-1:0]     limit;
  logic                            accept, commit;
  logic                            ram_re, ram_we;
  logic [rrts_pkg::RamAw-1:0]      ram_raddr, ram_waddr;
  logic [rrts_pkg::TaskW-1:0]      ram_rdata;
  logic [rrts_pkg::IdxW-1:0]       push_pos;

  // configuration registers
  rrts_apb_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .limit_o (limit)
  );

  // decode the incoming request against the current state
  rrts_plan u_plan (
    .opcode_i    (rrts_pkg::op_e'(s_axis_tuser)),
    .task_id_i   (s_axis_tdata[3:0]),
    .rd_count_i  (s_axis_tdata[11:4]),
    .wr_count_i  (s_axis_tdata[19:12]),
    .limit_i     (limit),
    .cur_task_i  (cur_task_q),
    .cur_valid_i (cur_valid_q),
    .counts_i    (counts_q),
    .plan_o      (plan_now)
  );

  assign s_axis_tready = (state_q == S_IDLE);
  assign accept        = s_axis_tvalid && s_axis_tready;
  // commit once the output register is free or being emptied
  assign commit        = (state_q == S_COMMIT) && (!out_valid_q || m_axis_tready);

  // read the head of the ring to dequeue as the request is accepted
  assign ram_re    = accept && plan_now.pop_en;
  assign ram_raddr = {plan_now.pop_ring,
                      rrts_pkg::head_sel(heads_q, plan_now.pop_ring)};

  // write the tail in the commit cycle; heads and counts are still those
  // seen at acceptance, so the tail slot is taken before the pop
  assign push_pos  = rrts_pkg::tail_pos(rrts_pkg::head_sel(heads_q, plan_q.push_ring),
                                        rrts_pkg::count_sel(counts_q, plan_q.push_ring));
  assign ram_we    = commit && plan_q.push_en;
  assign ram_waddr = {plan_q.push_ring, push_pos};

  rrts_ram #(
    .Width (rrts_pkg::TaskW),
    .Depth (rrts_pkg::RamDepth)
  ) u_ring_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (plan_q.push_task),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // state updates and result of the committing request
  always_comb begin
    state_d     = state_q;
    heads_d     = heads_q;
    counts_d    = counts_q;
    cur_task_d  = cur_task_q;
    cur_valid_d = cur_valid_q;

    // advance pointers and counts per ring
    for (int r = 0; r < rrts_pkg::NumRings; r++) begin
      if (commit && plan_q.pop_en && (plan_q.pop_ring == rrts_pkg::ring_e'(r))) begin
        heads_d[r] = rrts_pkg::idx_inc(heads_q[r]);
      end
      if (commit) begin
        counts_d[r] = counts_q[r]
          + rrts_pkg::CntW'(plan_q.push_en && (plan_q.push_ring == rrts_pkg::ring_e'(r)))
          - rrts_pkg::CntW'(plan_q.pop_en  && (plan_q.pop_ring  == rrts_pkg::ring_e'(r)));
      end
    end

    if (commit) begin
      if (plan_q.pop_en) begin
        cur_task_d  = ram_rdata;
        cur_valid_d = 1'b1;
      end else if (plan_q.go_idle) begin
        cur_task_d  = '0;
        cur_valid_d = 1'b0;
      end
    end

    res_d.status        = plan_q.status;
    res_d.switched      = plan_q.sw_cmp ? (ram_rdata != cur_task_q) : plan_q.sw_fix;
    res_d.old_task      = cur_valid_q ? cur_task_q : '0;
    res_d.running_valid = cur_valid_d;
    res_d.new_task      = cur_valid_d ? cur_task_d : '0;

    unique case (state_q)
      S_IDLE: begin
        if (accept) begin
          state_d = S_COMMIT;
        end
      end
      S_COMMIT: begin
        if (commit) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // output register: load on commit, drop when taken
  always_comb begin
    out_valid_d = out_valid_q;
    if (commit) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      heads_q     <= '0;
      counts_q    <= '0;
      cur_task_q  <= '0;
      cur_valid_q <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      heads_q     <= heads_d;
      counts_q    <= counts_d;
      cur_task_q  <= cur_task_d;
      cur_valid_q <= cur_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      plan_q <= plan_now;
    end
    if (commit) begin
      out_res_q <= res_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = rrts_pkg::OutDataW'(out_res_q);

endmodule
